>>> sv/udc_pkg.sv
// shared types, constants and the segment decoder for the up/down counter display
package udc_pkg;

  localparam int COUNT_W       = 14;
  localparam int RADIX_W       = 5;
  localparam int SEG_W         = 8;
  localparam int SEL_W         = 4;
  localparam int REM_W         = 4;
  localparam int MAX_DIGITS    = 4;
  localparam int DIGITS_DEFAULT = 4;

  localparam logic [COUNT_W-1:0] COUNT_MAX   = COUNT_W'(9999);
  localparam logic [RADIX_W-1:0] RADIX_RESET = RADIX_W'(10);
  localparam logic [RADIX_W-1:0] RADIX_MIN   = RADIX_W'(2);
  localparam logic [RADIX_W-1:0] RADIX_MAX   = RADIX_W'(16);

  // divider: dividend padded to a whole number of steps, several steps per cycle
  localparam int DIV_STEPS  = 4;
  localparam int DIV_W      = ((COUNT_W + DIV_STEPS - 1) / DIV_STEPS) * DIV_STEPS;
  localparam int DIV_CYCLES = DIV_W / DIV_STEPS;
  localparam int DIV_CNT_W  = (DIV_CYCLES > 1) ? $clog2(DIV_CYCLES) : 1;

  typedef struct packed {
    logic               done;
    logic [COUNT_W-1:0] quot;
    logic [REM_W-1:0]   rem;
  } udc_div_res_t;

  // active-low seven-segment pattern, point off
  function automatic logic [SEG_W-1:0] seg_of(input logic [REM_W-1:0] digit);
    logic [SEG_W-1:0] seg;
    case (digit)
      4'h0:    seg = 8'hC0;
      4'h1:    seg = 8'hF9;
      4'h2:    seg = 8'hA4;
      4'h3:    seg = 8'hB0;
      4'h4:    seg = 8'h99;
      4'h5:    seg = 8'h92;
      4'h6:    seg = 8'h82;
      4'h7:    seg = 8'hF8;
      4'h8:    seg = 8'h80;
      4'h9:    seg = 8'h90;
      4'hA:    seg = 8'h88;
      4'hB:    seg = 8'h83;
      4'hC:    seg = 8'hA7;
      4'hD:    seg = 8'hA1;
      4'hE:    seg = 8'h86;
      default: seg = 8'h8E;
    endcase
    return seg;
  endfunction

endpackage

>>> sv/udc_div.sv
// iterative restoring divider, count by radix, a few quotient bits per cycle
module udc_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [udc_pkg::COUNT_W-1:0]   dividend_i,
  input  logic [udc_pkg::RADIX_W-1:0]   divisor_i,
  output udc_pkg::udc_div_res_t         res_o
);
  import udc_pkg::*;

  logic                  busy_q, busy_d;
  logic                  done_q, done_d;
  logic [DIV_CNT_W-1:0]  cnt_q, cnt_d;
  logic [DIV_W-1:0]      sh_q, sh_d;
  logic [RADIX_W-1:0]    rem_q, rem_d;
  logic [RADIX_W-1:0]    div_q, div_d;

  // a few dependent compare-subtract steps on a 5-bit remainder
  always_comb begin
    logic [DIV_W-1:0]   sh;
    logic [RADIX_W-1:0] r;
    sh     = sh_q;
    r      = rem_q;
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    div_d  = div_q;
    if (start_i) begin
      sh     = DIV_W'(dividend_i);
      r      = '0;
      busy_d = 1'b1;
      cnt_d  = '0;
      div_d  = divisor_i;
    end else if (busy_q) begin
      for (int k = 0; k < DIV_STEPS; k++) begin
        r  = {r[RADIX_W-2:0], sh[DIV_W-1]};
        sh = {sh[DIV_W-2:0], 1'b0};
        if (r >= div_q) begin
          r     = r - div_q;
          sh[0] = 1'b1;
        end
      end
      cnt_d = cnt_q + DIV_CNT_W'(1);
      if (cnt_q == DIV_CNT_W'(DIV_CYCLES - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
    sh_d  = sh;
    rem_d = r;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sh_q  <= sh_d;
    rem_q <= rem_d;
    div_q <= div_d;
  end

  assign res_o.done = done_q;
  assign res_o.quot = sh_q[COUNT_W-1:0];
  assign res_o.rem  = rem_q[REM_W-1:0];

endmodule

>>> sv/up_down_counter_radix_display_top.sv
// top level: button edge counter with radix digit split onto a seven-segment display
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+------------------------------------------
//  in      | to block  | in_valid_i, in_stall_o | up_button_i, down_button_i
//  out     | from block| out_valid_o,out_stall_i| segments_o, digit_select_o, last_digit_o
//  cfg     | to block  | cfg_we_i               | cfg_wdata_i (radix)
//
//  one button transaction gives one result per digit, digit 0 first
//  per digit: the divider iterations, then the digit is registered and held on the
//  output until it is taken; the next digit's division starts once it is taken
//  the block returns to idle before the next acceptance; in_stall_o is high from
//  acceptance until the last digit is taken
//  reset clears the count, the held flags and loads radix 10; no clearing pass
module up_down_counter_radix_display_top #(
  parameter int DIGITS = udc_pkg::DIGITS_DEFAULT
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          up_button_i,
  input  logic                          down_button_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [udc_pkg::SEG_W-1:0]     segments_o,
  output logic [udc_pkg::SEL_W-1:0]     digit_select_o,
  output logic                          last_digit_o,
  input  logic                          cfg_we_i,
  input  logic [udc_pkg::RADIX_W-1:0]   cfg_wdata_i
);
  import udc_pkg::*;

  // results per transaction are capped by the width of the digit select
  localparam int NumDigits = (DIGITS > MAX_DIGITS) ? MAX_DIGITS :
                             ((DIGITS < 1) ? 1 : DIGITS);
  localparam int DigW      = (NumDigits > 1) ? $clog2(NumDigits) : 1;

  typedef enum logic [1:0] {
    StIdle,
    StDiv,
    StOut
  } state_e;

  state_e               state_q, state_d;
  logic [COUNT_W-1:0]   count_q, count_d;
  logic                 up_held_q, up_held_d;
  logic                 down_held_q, down_held_d;
  logic [RADIX_W-1:0]   radix_q, radix_d;
  logic [COUNT_W-1:0]   rest_q, rest_d;
  logic [DigW-1:0]      dig_q, dig_d;
  logic [SEG_W-1:0]     seg_q, seg_d;
  logic [SEL_W-1:0]     sel_q, sel_d;
  logic                 last_q, last_d;

  logic                 in_accept;
  logic                 out_accept;
  logic                 div_start;
  logic [COUNT_W-1:0]   div_dividend;
  logic [RADIX_W-1:0]   eff_radix;
  logic [COUNT_W-1:0]   count_inc;
  udc_div_res_t         div_res;

  assign in_stall_o  = (state_q != StIdle);
  assign in_accept   = in_valid_i && !in_stall_o;
  assign out_valid_o = (state_q == StOut);
  assign out_accept  = out_valid_o && !out_stall_i;

  // radix clamped into the supported range
  always_comb begin
    if (radix_q < RADIX_MIN) begin
      eff_radix = RADIX_MIN;
    end else if (radix_q > RADIX_MAX) begin
      eff_radix = RADIX_MAX;
    end else begin
      eff_radix = radix_q;
    end
  end

  // rising press of up first, then of down, both saturating
  always_comb begin
    count_inc = count_q;
    if (up_button_i && !up_held_q && (count_q < COUNT_MAX)) begin
      count_inc = count_q + COUNT_W'(1);
    end
    count_d = count_inc;
    if (down_button_i && !down_held_q && (count_inc != '0)) begin
      count_d = count_inc - COUNT_W'(1);
    end
  end

  // divider loads on a new transaction or on each digit taken but the last
  assign div_start    = in_accept || (out_accept && !last_q);
  assign div_dividend = in_accept ? count_d : rest_q;

  udc_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (eff_radix),
    .res_o      (div_res)
  );

  always_comb begin
    state_d     = state_q;
    up_held_d   = up_held_q;
    down_held_d = down_held_q;
    radix_d     = radix_q;
    rest_d      = rest_q;
    dig_d       = dig_q;
    seg_d       = seg_q;
    sel_d       = sel_q;
    last_d      = last_q;
    if (cfg_we_i) begin
      radix_d = cfg_wdata_i;
    end
    case (state_q)
      StIdle: begin
        if (in_accept) begin
          up_held_d   = up_button_i;
          down_held_d = down_button_i;
          dig_d       = '0;
          state_d     = StDiv;
        end
      end
      StDiv: begin
        if (div_res.done) begin
          rest_d  = div_res.quot;
          seg_d   = seg_of(div_res.rem);
          sel_d   = ~(SEL_W'(1) << dig_q);
          last_d  = (dig_q == DigW'(NumDigits - 1));
          state_d = StOut;
        end
      end
      StOut: begin
        if (out_accept) begin
          if (last_q) begin
            state_d = StIdle;
          end else begin
            dig_d   = dig_q + DigW'(1);
            state_d = StDiv;
          end
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // control state and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      count_q     <= '0;
      up_held_q   <= 1'b0;
      down_held_q <= 1'b0;
      radix_q     <= RADIX_RESET;
      dig_q       <= '0;
      last_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      if (in_accept) begin
        count_q <= count_d;
      end
      up_held_q   <= up_held_d;
      down_held_q <= down_held_d;
      radix_q     <= radix_d;
      dig_q       <= dig_d;
      last_q      <= last_d;
    end
  end

  // payload, no reset needed
  always_ff @(posedge clk_i) begin
    rest_q <= rest_d;
    seg_q  <= seg_d;
    sel_q  <= sel_d;
  end

  assign segments_o     = seg_q;
  assign digit_select_o = sel_q;
  assign last_digit_o   = last_q;

  // count stays within the saturation limit
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= COUNT_MAX)
    else $error("count above saturation limit");

  // a shown digit has exactly one select line low
  a_sel_one_cold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> $onehot(~digit_select_o))
    else $error("digit select not one-cold");

  // divider only finishes while the sequencer waits for it
  a_div_done_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_res.done |-> (state_q == StDiv))
    else $error("divider result outside division state");

  // an accepted transaction sets the input stall
  a_in_blocked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> in_stall_o)
    else $error("input open during a transaction");

endmodule

>>> bench/tb_up_down_counter_radix_display_top.sv
`timescale 1ns / 100ps
// self-checking bench for the up/down counter with radix seven-segment display
module tb_up_down_counter_radix_display_top;
  import udc_pkg::*;

  localparam int SETTLE_CYCLES = 32;        // a little over one full transaction
  localparam int LONG_HOLD     = 250;       // receiver hold-off that backs up the input
  localparam int RUN_LIMIT_NS  = 4_000_000;

  typedef struct {
    logic [SEG_W-1:0] segments;
    logic [SEL_W-1:0] select;
    logic             last;
  } digit_t;

  // running model of the counter and its digit stream
  class digit_board;
    logic [RADIX_W-1:0] radix;
    logic [COUNT_W-1:0] level;
    bit                 up_held;
    bit                 down_held;
    digit_t             pending_digits[$];
    int                 errors;
    logic [SEG_W-1:0]   glyphs[16];

    function new();
      radix     = RADIX_RESET;
      level     = '0;
      up_held   = 1'b0;
      down_held = 1'b0;
      errors    = 0;
      glyphs    = '{8'hC0, 8'hF9, 8'hA4, 8'hB0, 8'h99, 8'h92, 8'h82, 8'hF8,
                    8'h80, 8'h90, 8'h88, 8'h83, 8'hA7, 8'hA1, 8'h86, 8'h8E};
    endfunction

    function int pending();
      return pending_digits.size();
    endfunction

    function void set_radix(logic [RADIX_W-1:0] value);
      radix = value;
    endfunction

    // one accepted button transaction: update the count, queue four digits
    function void note_press(bit up, bit down);
      int     base;
      int     rest;
      digit_t dig;
      if (up) begin
        if (!up_held) begin
          if (level < COUNT_MAX) level = level + 1'b1;
          up_held = 1'b1;
        end
      end else begin
        up_held = 1'b0;
      end
      if (down) begin
        if (!down_held) begin
          if (level != '0) level = level - 1'b1;
          down_held = 1'b1;
        end
      end else begin
        down_held = 1'b0;
      end
      base = (radix < 2) ? 2 : (radix > 16) ? 16 : int'(radix);
      rest = int'(level);
      for (int i = 0; i < MAX_DIGITS; i++) begin
        dig.segments = glyphs[rest % base];
        dig.select   = ~(SEL_W'(1) << i);
        dig.last     = (i == MAX_DIGITS - 1);
        rest         = rest / base;
        pending_digits.push_back(dig);
      end
    endfunction

    task report_mismatch(string what, int got, int want);
      $display("%0t mismatch on %s: got %0h, want %0h", $time, what, got, want);
      errors++;
    endtask

    task check_digit(logic [SEG_W-1:0] seg, logic [SEL_W-1:0] sel, logic last);
      digit_t want;
      if (pending_digits.size() == 0) begin
        report_mismatch("unexpected digit (segments)", seg, 0);
      end else begin
        want = pending_digits.pop_front();
        if (seg !== want.segments) report_mismatch("segments", seg, want.segments);
        if (sel !== want.select) report_mismatch("digit_select", sel, want.select);
        if (last !== want.last) report_mismatch("last_digit", last, want.last);
      end
    endtask
  endclass

  logic                 clk_i          = 1'b0;
  logic                 rst_ni         = 1'b0;
  logic                 in_valid_i     = 1'b0;
  logic                 up_button_i    = 1'b0;
  logic                 down_button_i  = 1'b0;
  logic                 out_stall_i    = 1'b0;
  logic                 cfg_we_i       = 1'b0;
  logic [RADIX_W-1:0]   cfg_wdata_i    = '0;
  logic                 in_stall_o;
  logic                 out_valid_o;
  logic [SEG_W-1:0]     segments_o;
  logic [SEL_W-1:0]     digit_select_o;
  logic                 last_digit_o;

  digit_board board = new();

  // calm: no gaps and no random stalls; hold_request: ask the receiver for a long hold-off
  bit calm         = 1'b0;
  bit hold_request = 1'b0;

  up_down_counter_radix_display_top dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .up_button_i    (up_button_i),
    .down_button_i  (down_button_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .segments_o     (segments_o),
    .digit_select_o (digit_select_o),
    .last_digit_o   (last_digit_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i)
  );

  // 20 ns clock
  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // hard stop in case the block locks up
  initial begin
    #(RUN_LIMIT_NS);
    $display("[up_down_counter_radix_display_top] ERROR");
    $finish;
  end

  // receiver: check every digit taken, then decide next cycle's stall
  int hold_left  = 0;
  int burst_left = 0;
  always @(posedge clk_i) begin
    int roll;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      board.check_digit(segments_o, digit_select_o, last_digit_o);
    end
    if (hold_request) begin
      hold_request = 1'b0;
      hold_left    = LONG_HOLD;
    end
    roll = $urandom_range(99);
    if (hold_left > 0) begin
      // long hold-off, counted here so the sender keeps pushing meanwhile
      hold_left--;
      out_stall_i <= 1'b1;
    end else if (calm) begin
      out_stall_i <= 1'b0;
    end else if (burst_left > 0) begin
      burst_left--;
      out_stall_i <= 1'b1;
    end else if (roll < 70) begin
      out_stall_i <= 1'b0;
    end else if (roll < 97) begin
      burst_left  = $urandom_range(2);
      out_stall_i <= 1'b1;
    end else begin
      burst_left  = $urandom_range(40, 15);
      out_stall_i <= 1'b1;
    end
  end

  // offer one button transaction and wait until it is taken; valid is left high unless an idle gap follows
  task automatic press(bit up, bit down);
    int gap;
    in_valid_i    <= 1'b1;
    up_button_i   <= up;
    down_button_i <= down;
    do @(posedge clk_i); while (in_stall_o);
    board.note_press(up, down);
    // idle gap: mostly none or short, now and then long
    gap = $urandom_range(99);
    if (calm || gap < 55) gap = 0;
    else if (gap < 90) gap = $urandom_range(3, 1);
    else gap = $urandom_range(40, 10);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // let every queued digit come out, then give the block time to fall idle
  task automatic drain();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (board.pending() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // radix writes happen only with the block idle
  task automatic write_radix(logic [RADIX_W-1:0] value);
    drain();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    board.set_radix(value);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // random button levels: fresh presses, holds and releases in any mix
  task automatic wander(int n);
    repeat (n) press(1'($urandom_range(1)), 1'($urandom_range(1)));
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: down at zero saturates, held buttons, both rising together
    press(0, 0);
    press(0, 1);
    press(0, 1);
    press(1, 1);   // up rising with down held
    press(1, 1);   // both held
    press(0, 0);
    press(1, 1);   // both rising: up then down, no net change
    press(0, 0);
    press(1, 0);
    press(1, 0);   // held up does nothing
    press(0, 0);
    press(1, 0);
    press(0, 1);   // up released and down rising in one transaction
    press(1, 1);
    press(0, 0);

    // radix below two and above sixteen get clamped; 0 and 31 cover every bit
    write_radix(RADIX_W'(1));
    press(1, 0);
    press(0, 0);
    write_radix(RADIX_W'(17));
    press(1, 0);
    write_radix(RADIX_W'(0));
    press(0, 0);
    write_radix(RADIX_W'(31));
    press(1, 0);

    // random walk near zero, assorted legal radices
    repeat (3) begin
      write_radix(RADIX_W'($urandom_range(16, 2)));
      wander(10);
    end

    // climb sixteen steps in hex: every glyph shows up in the lowest digit
    write_radix(RADIX_W'(16));
    calm = 1'b1;
    repeat (16) begin
      press(1, 0);
      press(0, 0);
    end
    calm = 1'b0;

    // decimal: single presses and both rising together
    write_radix(RADIX_W'(10));
    press(1, 0);
    press(0, 0);
    press(1, 1);   // both rising: up then down, no net change
    press(0, 0);
    press(1, 0);
    press(0, 0);

    // binary: the high digits of the count fall off the display
    write_radix(RADIX_W'(2));
    press(0, 1);
    press(0, 0);

    // random walk across the radix extremes
    write_radix(RADIX_W'(0));
    wander(12);
    write_radix(RADIX_W'(31));
    wander(12);
    write_radix(RADIX_W'($urandom_range(16, 2)));
    wander(12);

    // back-pressure: receiver holds off while the sender keeps offering
    calm         = 1'b1;
    hold_request = 1'b1;
    wander(12);
    calm = 1'b0;

    write_radix(RADIX_W'($urandom_range(31)));
    wander(12);

    drain();
    if (board.errors == 0) begin
      $display("[up_down_counter_radix_display_top] OK");
    end else begin
      $display("[up_down_counter_radix_display_top] ERROR");
    end
    $finish;
  end

endmodule
